/* rtl/icmpv6_checksum_generator_core_defines.svh */
// Assertion macros for the ICMPv6 checksum generator.
// Both expect signals named clk and arst_n in the enclosing scope.
`ifndef ICMPV6_CHECKSUM_GENERATOR_CORE_DEFINES_SVH
`define ICMPV6_CHECKSUM_GENERATOR_CORE_DEFINES_SVH

// Clocked property, held off while reset is asserted.
`define ICV6CS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ICV6CS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

/* rtl/icv6cs_pkg.sv */
package icv6cs_pkg;

	// One byte transaction as held in the input stage.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_address;
		logic       last;
	} item_t;

	// Control from the top level to the accumulator.
	typedef struct packed {
		logic advance;   // stage 1 item is consumed this cycle
	} acc_ctrl_t;

	localparam logic [15:0] NEXT_HEADER_ICMPV6 = 16'd58;
	localparam logic [15:0] CKSUM_ALL_ONES     = 16'hFFFF;

endpackage

/* rtl/icmpv6_checksum_generator_core.sv */
// Channel   Handshake                  Payload                          Direction
// in        in_valid / in_stall        data_byte, is_address, last      into block
// out       out_valid / out_stall      checksum                         out of block
//
// One byte transaction per cycle is accepted, back to back, while in_stall is low.
// A byte is held in the input register; when it advances it is folded into
// the running sum, and a last byte loads the checksum into the output register.
// An accepted last byte passes the input register, then the output register, before out_valid.
// Reset (arst_n low) clears the running sum, odd byte, length count and both valids.
// in_stall rises only when a last byte waits behind an unread checksum held by out_stall.
module icmpv6_checksum_generator_core #(
	parameter int LENGTH_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_address,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] checksum
);
	import icv6cs_pkg::*;

	// Stage 1: input register
	item_t     item_s1;
	logic      valid_s1;
	logic      s1_free;
	logic      in_take;
	acc_ctrl_t ctrl;
	logic [15:0] checksum_nxt;

	// Output register
	logic        out_valid_q;
	logic [15:0] checksum_q;

	// A non-last byte never needs the output register, so only a last byte
	// can be held up by a pending checksum.
	always_comb begin
		ctrl.advance = valid_s1 && (!item_s1.last || !out_valid_q || !out_stall);
		s1_free      = !valid_s1 || ctrl.advance;
		in_stall     = !s1_free;
		in_take      = in_valid && s1_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.data_byte  <= data_byte;
			item_s1.is_address <= is_address;
			item_s1.last       <= last;
		end
	end

	icv6cs_accum #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.ctrl        (ctrl),
		.checksum_nxt(checksum_nxt)
	);

	// Result register: loads on a consumed last byte, drains when not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.advance && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance && item_s1.last) begin
			checksum_q <= checksum_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;

endmodule

/* rtl/icv6cs_accum.sv */
module icv6cs_accum #(
	parameter int LENGTH_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  icv6cs_pkg::item_t   item_s1,
	input  icv6cs_pkg::acc_ctrl_t ctrl,
	output logic [15:0]         checksum_nxt
);
	import icv6cs_pkg::*;

	localparam logic [LENGTH_BITS-1:0] CNT_MAX     = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] CKFIELD_LO  = LENGTH_BITS'(2);
	localparam logic [LENGTH_BITS-1:0] CKFIELD_HI  = LENGTH_BITS'(3);

	logic [15:0]            sum_q;
	logic [7:0]             held_q;
	logic                   pend_q;
	logic [LENGTH_BITS-1:0] count_q;

	logic                   skip;
	logic                   summed;
	logic                   pair_add;
	logic                   pend_after;
	logic [7:0]             held_after;
	logic [15:0]            word;
	logic [LENGTH_BITS-1:0] count_nxt;
	logic [31:0]            len32;
	logic [18:0]            total;
	logic [16:0]            fold1;
	logic [15:0]            folded;
	logic [15:0]            inv;

	always_comb begin
		// checksum field of the message is left out of the sum
		skip       = !item_s1.is_address && (count_q == CKFIELD_LO || count_q == CKFIELD_HI);
		summed     = !skip;
		pair_add   = summed && pend_q;
		pend_after = summed ? !pend_q : pend_q;
		held_after = (summed && !pend_q) ? item_s1.data_byte : held_q;

		// at most one data word per byte: a completed pair or the padded odd byte
		if (pair_add) begin
			word = {held_q, item_s1.data_byte};
		end else if (item_s1.last && pend_after) begin
			word = {held_after, 8'h00};
		end else begin
			word = 16'h0000;
		end

		if (item_s1.is_address || count_q == CNT_MAX) begin
			count_nxt = count_q;
		end else begin
			count_nxt = count_q + LENGTH_BITS'(1);
		end
		len32 = 32'(count_nxt);

		total = 19'(sum_q) + 19'(word);
		if (item_s1.last) begin
			total = total + 19'(len32[31:16]) + 19'(len32[15:0]) + 19'(NEXT_HEADER_ICMPV6);
		end

		// end-around carry, twice
		fold1  = 17'(total[15:0]) + 17'(total[18:16]);
		folded = fold1[15:0] + 16'(fold1[16]);

		inv          = ~folded;
		checksum_nxt = (inv == 16'h0000) ? CKSUM_ALL_ONES : inv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			held_q  <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
		end else if (ctrl.advance) begin
			if (item_s1.last) begin
				sum_q   <= '0;
				held_q  <= '0;
				pend_q  <= 1'b0;
				count_q <= '0;
			end else begin
				sum_q   <= folded;
				held_q  <= held_after;
				pend_q  <= pend_after;
				count_q <= count_nxt;
			end
		end
	end

endmodule

/* rtl/icv6cs_chk.sv */
module icv6cs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  data_byte,
	input logic        is_address,
	input logic        last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] checksum
);
`include "icmpv6_checksum_generator_core_defines.svh"

	// held result stays put
	`ICV6CS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(checksum), "checksum changed while stalled")
	// zero is always mapped to all ones
	`ICV6CS_NEVER(a_no_zero, out_valid && checksum == 16'h0000, "zero checksum emitted")
	// input only backs up behind a stalled result
	`ICV6CS_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")

endmodule

bind icmpv6_checksum_generator_core icv6cs_chk u_chk (.*);

/* verif/icmpv6_checksum_checker.sv */
`timescale 1ns / 1ps

module icmpv6_checksum_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        is_address,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] checksum,
	output int          mismatches,
	output int          awaiting,
	output int          checked
);
	import icv6cs_pkg::*;

	localparam logic [31:0] LEN_SAT = '1;

	// running one's complement sum of the packet in flight
	logic [16:0] sum_acc;
	logic [7:0]  held_hi;
	logic        odd_pend;
	logic [31:0] msg_len;

	logic [15:0] cksum_q[$];
	int          errs;
	int          seen;

	function automatic void clear_packet();
		sum_acc = '0;
		held_hi = '0;
		odd_pend = 1'b0;
		msg_len = '0;
	endfunction

	// end-around carry folded right away, so sum_acc never exceeds 16'hFFFF
	function automatic void fold_word(input logic [15:0] w);
		logic [16:0] s;
		s = sum_acc + 17'(w);
		sum_acc = 17'(s[15:0]) + 17'(s[16]);
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		if (odd_pend) begin
			fold_word({held_hi, b});
			odd_pend = 1'b0;
			held_hi = '0;
		end else begin
			held_hi = b;
			odd_pend = 1'b1;
		end
	endfunction

	function automatic logic [15:0] close_packet();
		logic [15:0] r;
		if (odd_pend)
			fold_word({held_hi, 8'h00});
		fold_word(msg_len[31:16]);
		fold_word(msg_len[15:0]);
		fold_word(NEXT_HEADER_ICMPV6);
		r = ~sum_acc[15:0];
		if (r == 16'h0000)
			r = CKSUM_ALL_ONES;
		clear_packet();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			clear_packet();
			cksum_q.delete();
		end else begin
			// results first, so a fresh expectation can never hide a stray result
			if (out_valid && !out_stall) begin
				seen++;
				if (cksum_q.size() == 0) begin
					errs++;
					$error("checksum: result %h with nothing expected", checksum);
				end else begin
					want = cksum_q.pop_front();
					if (checksum !== want) begin
						errs++;
						$error("checksum mismatch: expected %h, actual %h", want, checksum);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (is_address) begin
					take_byte(data_byte);
				end else begin
					// bytes 2 and 3 are the checksum field itself
					if (msg_len != 32'd2 && msg_len != 32'd3)
						take_byte(data_byte);
					if (msg_len != LEN_SAT)
						msg_len++;
				end
				if (last)
					cksum_q.push_back(close_packet());
			end
		end
		mismatches <= errs;
		awaiting <= cksum_q.size();
		checked <= seen;
	end

endmodule

/* verif/icmpv6_checksum_generator_core_test.sv */
`timescale 1ns / 1ps

module icmpv6_checksum_generator_core_test;

	// clock and reset
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	// input channel: one byte transaction per handshake
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        is_address = 1'b0;
	logic        last = 1'b0;

	// output channel: one checksum per packet
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] checksum;

	// checker feedback
	int mismatches;
	int awaiting;
	int checked;

	// stimulus bookkeeping
	int items_sent = 0;
	int packets_sent = 0;

	// traffic shaping flags
	logic tx_quiet = 1'b0;   // sender never idles while set
	logic rx_quiet = 1'b0;   // receiver never stalls while set
	logic hold_req = 1'b0;   // asks the receiver for one long hold-off
	logic hold_done = 1'b0;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	always #4 clk = ~clk;

	icmpv6_checksum_generator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.is_address (is_address),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.checksum   (checksum)
	);

	icmpv6_checksum_checker scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.is_address (is_address),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.checksum   (checksum),
		.mismatches (mismatches),
		.awaiting   (awaiting),
		.checked    (checked)
	);

	// Offer one byte and hold it until the block takes it. Valid stays high
	// straight into the next transaction unless a random gap is drawn, so each
	// signal sees at most one nonblocking write per edge.
	task automatic send_byte(input logic [7:0] b, input logic a, input logic l);
		if (!tx_quiet && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		is_address <= a;
		last <= l;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Pause the sender until every predicted checksum has been read back.
	// awaiting reflects the state after the previous edge, hence the first wait.
	task automatic wait_drained();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// 32 address bytes, then a message; this is the only shape that exercises
	// the full pseudo-header path, so it carries most of the random traffic.
	task automatic send_proper_packet();
		int mlen;
		if ($urandom_range(0, 9) == 0)
			mlen = $urandom_range(13, 40);
		else
			mlen = $urandom_range(1, 12);
		for (int i = 0; i < 32; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		for (int i = 0; i < mlen; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0, i == mlen - 1);
		packets_sent++;
	endtask

	// Address run of random length, from 0 to 40 bytes, followed by a message.
	task automatic send_short_header_packet();
		int alen;
		int mlen;
		alen = $urandom_range(0, 40);
		mlen = $urandom_range(1, 8);
		for (int i = 0; i < alen; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		for (int i = 0; i < mlen; i++)
			send_byte(8'($urandom_range(0, 255)), 1'b0, i == mlen - 1);
		packets_sent++;
	endtask

	// Noise: address flags drawn per byte, so address bytes land mid-message
	// and the closing byte may itself be an address byte.
	task automatic send_noise_packet(input int max_len);
		int n;
		n = $urandom_range(1, max_len);
		for (int i = 0; i < n; i++)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), i == n - 1);
		packets_sent++;
	endtask

	// Receiver: random stalls, one long hold-off on request, quiet windows.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !rx_quiet && ($urandom_range(0, 99) < 26);
			end
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#3_200_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int rnd_pkts;
		int kind;
		rnd_pkts = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part ----
		// lone address byte that also closes the packet
		send_byte(8'hFF, 1'b1, 1'b1);
		packets_sent++;
		// one-byte message, all zeros
		send_byte(8'h00, 1'b0, 1'b1);
		packets_sent++;
		// 4-byte message tuned so the folded sum is all ones: the complement is
		// zero and must come out as FFFF; bytes 2 and 3 are skipped
		send_byte(8'hFF, 1'b0, 1'b0);
		send_byte(8'hC1, 1'b0, 1'b0);
		send_byte(8'hAA, 1'b0, 1'b0);
		send_byte(8'h55, 1'b0, 1'b1);
		packets_sent++;
		// odd length ending inside the checksum field
		send_byte(8'h12, 1'b0, 1'b0);
		send_byte(8'h34, 1'b0, 1'b0);
		send_byte(8'h56, 1'b0, 1'b1);
		packets_sent++;
		// address bytes after message bytes share the byte pairing
		send_byte(8'h80, 1'b1, 1'b0);
		send_byte(8'h01, 1'b1, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b0);
		send_byte(8'hFE, 1'b1, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		packets_sent++;
		// odd byte pending at the end, mixed bit patterns
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'hFE, 1'b0, 1'b0);
		send_byte(8'h55, 1'b0, 1'b1);
		packets_sent++;

		// sender pause: everything predicted so far must come back first
		wait_drained();

		// ---- random part ----
		while (items_sent < 430 || packets_sent < 40) begin
			if (rnd_pkts == 6) begin
				// long receiver hold-off while short packets keep coming: the
				// output register fills and a last byte has to stall the input
				hold_req <= 1'b1;
				tx_quiet <= 1'b1;
				for (int i = 0; i < 15; i++)
					send_noise_packet(3);
				tx_quiet <= 1'b0;
				wait_drained();
			end
			if (rnd_pkts == 12) begin
				tx_quiet <= 1'b1;
				rx_quiet <= 1'b1;
			end
			if (rnd_pkts == 20) begin
				tx_quiet <= 1'b0;
				rx_quiet <= 1'b0;
				wait_drained();
			end
			kind = $urandom_range(0, 99);
			if (kind < 60)
				send_proper_packet();
			else if (kind < 75)
				send_short_header_packet();
			else
				send_noise_packet(10);
			rnd_pkts++;
		end

		// wind down: all results back, then a few more cycles for strays
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d byte transactions in %0d packets; %0d checksums compared.",
			items_sent, packets_sent, checked);
		$display("Included a %0d-cycle output hold-off, sender drains and gap-free stretches.",
			HOLD_CYCLES);
		if (mismatches == 0 && awaiting == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
